// File: design/varc_pkg.sv
// ----------------------------------------------------------------------------
// varc_pkg
// Shared widths, CORDIC constants and helpers for the axis-angle rotation core.
// ----------------------------------------------------------------------------
package varc_pkg;

  localparam int unsigned Frac        = 29;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned SqrtSteps   = 34;  // result bits of sqrt of a 68-bit value
  localparam int unsigned DivSteps    = 31;  // quotient bits, quotient < 2^31

  localparam logic signed [35:0] CordicStart = 36'sd326016437;
  localparam logic signed [35:0] OneFx       = 36'sd536870912;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        5'd28: r = 32'd3;
        5'd29: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // Round half up from Q(x).29 product back to Q16.16 scale.
  function automatic logic signed [39:0] rnd29(input logic signed [68:0] v);
    logic signed [68:0] t;
    begin
      t = v + 69'sd268435456;
      return 40'(t >>> Frac);
    end
  endfunction

endpackage

// File: design/varc_sqrt.sv
// ----------------------------------------------------------------------------
// varc_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// Side data rides along with each item.
// ----------------------------------------------------------------------------
module varc_sqrt #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [67:0]      num_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [33:0]      root_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned N = varc_pkg::SqrtSteps;

  logic [N-1:0]     vld_q;
  logic [67:0]      rem_q  [N];
  logic [33:0]      res_q  [N];
  logic [SideW-1:0] sd_q   [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic             vld_c;
    logic [67:0]      rem_c;
    logic [33:0]      res_c;
    logic [SideW-1:0] sd_c;
    logic [35:0]      trial;
    logic [35:0]      remhi;
    logic [67:0]      rem_d;
    logic [33:0]      res_d;
    if (g == 0) begin : g_first
      assign vld_c = valid_i;
      assign rem_c = num_i;
      assign res_c = '0;
      assign sd_c  = side_i;
    end else begin : g_next
      assign vld_c = vld_q[g-1];
      assign rem_c = rem_q[g-1];
      assign res_c = res_q[g-1];
      assign sd_c  = sd_q[g-1];
    end
    // Bit 2*(N-1-g): compare remainder top against (res<<2 | 1) scaled.
    always_comb begin
      remhi = 36'(rem_c >> (2 * (N - 1 - g)));
      trial = {res_c, 2'b01};
      rem_d = rem_c;
      res_d = {res_c[32:0], 1'b0};
      if (remhi >= trial) begin
        rem_d = rem_c - (68'(trial) << (2 * (N - 1 - g)));
        res_d = {res_c[32:0], 1'b1};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        res_q[g] <= res_d;
        sd_q[g]  <= sd_c;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = res_q[N-1];
  assign side_o  = sd_q[N-1];

endmodule

// File: design/varc_div.sv
// ----------------------------------------------------------------------------
// varc_div
// Pipelined restoring divider for (m*2^29 + n/2) / n, one quotient bit per
// stage; three lanes share the divisor. Side data rides along.
// ----------------------------------------------------------------------------
module varc_div #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [61:0]      num_i [3],
  input  logic [33:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [30:0]      quo_o [3],
  output logic [SideW-1:0] side_o
);

  localparam int unsigned N = varc_pkg::DivSteps;

  logic [N-1:0]     vld_q;
  logic [61:0]      rem_q [N][3];
  logic [30:0]      quo_q [N][3];
  logic [33:0]      den_q [N];
  logic [SideW-1:0] sd_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int unsigned Sh = N - 1 - g;
    logic             vld_c;
    logic [61:0]      rem_c [3];
    logic [30:0]      quo_c [3];
    logic [33:0]      den_c;
    logic [SideW-1:0] sd_c;
    logic [61:0]      rem_d [3];
    logic [30:0]      quo_d [3];
    if (g == 0) begin : g_first
      assign vld_c = valid_i;
      assign rem_c = num_i;
      assign quo_c = '{default: '0};
      assign den_c = den_i;
      assign sd_c  = side_i;
    end else begin : g_next
      assign vld_c = vld_q[g-1];
      assign rem_c = rem_q[g-1];
      assign quo_c = quo_q[g-1];
      assign den_c = den_q[g-1];
      assign sd_c  = sd_q[g-1];
    end
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [95:0] sub;
        sub = 96'(den_c) << Sh;
        rem_d[l] = rem_c[l];
        quo_d[l] = {quo_c[l][29:0], 1'b0};
        if (96'(rem_c[l]) >= sub) begin
          rem_d[l] = rem_c[l] - 62'(sub);
          quo_d[l] = {quo_c[l][29:0], 1'b1};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        quo_q[g] <= quo_d;
        den_q[g] <= den_c;
        sd_q[g]  <= sd_c;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = sd_q[N-1];

endmodule

// File: design/varc_cordic.sv
// ----------------------------------------------------------------------------
// varc_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving
// cosine and sine in Q2.29 with quadrant fold and clamp.
// ----------------------------------------------------------------------------
module varc_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] angle_i,
  output logic signed [30:0] cos_o,
  output logic signed [30:0] sin_o
);

  localparam int unsigned N = varc_pkg::CordicSteps;

  logic signed [35:0] x_q [N];
  logic signed [35:0] y_q [N];
  logic signed [33:0] z_q [N];
  logic [N-1:0]       fl_q;

  logic signed [33:0] t;
  logic signed [33:0] z0;
  logic               flip;

  always_comb begin
    t    = 34'(angle_i);
    flip = (t > 34'sd1073741824) || (t < -34'sd1073741824);
    z0   = t;
    if (flip) begin
      z0 = (t > 0) ? t - 34'sd2147483648 : t + 34'sd2147483648;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [35:0] x_c, y_c;
    logic signed [33:0] z_c;
    logic               fl_c;
    logic signed [35:0] xs, ys;
    logic signed [33:0] at;
    if (g == 0) begin : g_first
      assign x_c  = varc_pkg::CordicStart;
      assign y_c  = '0;
      assign z_c  = z0;
      assign fl_c = flip;
    end else begin : g_next
      assign x_c  = x_q[g-1];
      assign y_c  = y_q[g-1];
      assign z_c  = z_q[g-1];
      assign fl_c = fl_q[g-1];
    end
    always_comb begin
      xs = x_c >>> g;
      ys = y_c >>> g;
      at = 34'(varc_pkg::atan_lut(5'(g)));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[g] <= fl_c;
        if (z_c >= 0) begin
          x_q[g] <= x_c - ys;
          y_q[g] <= y_c + xs;
          z_q[g] <= z_c - at;
        end else begin
          x_q[g] <= x_c + ys;
          y_q[g] <= y_c - xs;
          z_q[g] <= z_c + at;
        end
      end
    end
  end

  logic signed [35:0] xc, yc;
  always_comb begin
    xc = x_q[N-1];
    yc = y_q[N-1];
    if (xc > varc_pkg::OneFx) xc = varc_pkg::OneFx;
    if (xc < -varc_pkg::OneFx) xc = -varc_pkg::OneFx;
    if (yc > varc_pkg::OneFx) yc = varc_pkg::OneFx;
    if (yc < -varc_pkg::OneFx) yc = -varc_pkg::OneFx;
    if (fl_q[N-1]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_o = 31'(xc);
  assign sin_o = 31'(yc);

endmodule

// File: design/vector_axis_angle_rotation_core.sv
// ----------------------------------------------------------------------------
// vector_axis_angle_rotation_core
// Rotates a Q16.16 vector about an axis of any length by a binary angle.
// ----------------------------------------------------------------------------
// Usage: present vec_*, axis_*, turn_angle with in_valid_i; an item is taken
// at a clock edge where in_valid_i is high and in_stall_o is low. Results
// appear on out_x/y/z_o with out_valid_o and are taken where out_stall_i is
// low. Throughput: one item per cycle while not stalled. Pipeline: 34
// square-root stages, 31 divider stages and 5 product stages lie between
// acceptance and the result register. The sin/cos CORDIC (30 stages)
// runs beside the square root and divider and its results are delayed to
// meet the unit axis. The whole pipeline advances together; when the
// receiver stalls with a result waiting, every stage holds and in_stall_o
// is raised, so nothing is lost or repeated. Reset clears all valid bits;
// data registers carry no reset.
// ----------------------------------------------------------------------------
module vector_axis_angle_rotation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [31:0] axis_x_i,
  input  logic [31:0] axis_y_i,
  input  logic [31:0] axis_z_i,
  input  logic [31:0] turn_angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o
);

  localparam int unsigned CosDelay = varc_pkg::SqrtSteps + varc_pkg::DivSteps
                                     - varc_pkg::CordicSteps;

  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // square root of |a|^2 sum; side carries v and a
  logic [31:0] m [3];
  logic [67:0] sq;
  always_comb begin
    m[0] = axis_x_i[31] ? 32'(-axis_x_i) : axis_x_i;
    m[1] = axis_y_i[31] ? 32'(-axis_y_i) : axis_y_i;
    m[2] = axis_z_i[31] ? 32'(-axis_z_i) : axis_z_i;
    sq   = 68'(64'(m[0]) * 64'(m[0])) + 68'(64'(m[1]) * 64'(m[1]))
         + 68'(64'(m[2]) * 64'(m[2]));
  end

  logic         sq_vld;
  logic [33:0]  root;
  logic [191:0] sq_side;
  varc_sqrt #(.SideW(192)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .num_i(sq),
    .side_i({vec_x_i, vec_y_i, vec_z_i, axis_x_i, axis_y_i, axis_z_i}),
    .valid_o(sq_vld), .root_o(root), .side_o(sq_side)
  );

  logic [31:0] ax [3];
  logic [61:0] dnum [3];
  logic [33:0] den;
  always_comb begin
    ax[0] = sq_side[95:64];
    ax[1] = sq_side[63:32];
    ax[2] = sq_side[31:0];
    den   = (root == '0) ? 34'd1 : root;
    for (int l = 0; l < 3; l++) begin
      logic [31:0] am;
      am = ax[l][31] ? 32'(-ax[l]) : ax[l];
      dnum[l] = (62'(am) << varc_pkg::Frac) + 62'(root >> 1);
    end
  end

  // side: v, axis signs, zero-axis flag
  logic         dv_vld;
  logic [30:0]  quo [3];
  logic [99:0]  dv_side;
  varc_div #(.SideW(100)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld), .num_i(dnum), .den_i(den),
    .side_i({sq_side[191:96], ax[0][31], ax[1][31], ax[2][31], (root == '0)}),
    .valid_o(dv_vld), .quo_o(quo), .side_o(dv_side)
  );

  // cos/sin beside; delay to line up with the divider output
  logic signed [30:0] c_raw, s_raw;
  varc_cordic u_cordic (
    .clk_i, .en_i(en), .angle_i(turn_angle_i),
    .cos_o(c_raw), .sin_o(s_raw)
  );

  logic signed [30:0] cd_q [CosDelay];
  logic signed [30:0] sd_q [CosDelay];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= c_raw;
      sd_q[0] <= s_raw;
      for (int i = 1; i < CosDelay; i++) begin
        cd_q[i] <= cd_q[i-1];
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // stage A: unit axis
  logic signed [31:0] u_d [3];
  logic signed [31:0] v_d [3];
  always_comb begin
    v_d[0] = dv_side[99:68];
    v_d[1] = dv_side[67:36];
    v_d[2] = dv_side[35:4];
    for (int l = 0; l < 3; l++) begin
      u_d[l] = dv_side[0] ? 32'sd0
             : (dv_side[3-l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]}));
    end
  end

  // stage 1: u and v registered, products for cross and dot
  logic [3:0]         vld_q;
  logic signed [31:0] u1_q [3], v1_q [3];
  logic signed [30:0] c1_q, s1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= u_d;
      v1_q <= v_d;
      c1_q <= cd_q[CosDelay-1];
      s1_q <= sd_q[CosDelay-1];
    end
  end

  // stage 2: cross, dot
  logic signed [39:0] cr2_q [3];
  logic signed [39:0] d2_q;
  logic signed [31:0] u2_q [3], v2_q [3];
  logic signed [30:0] c2_q, s2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cr2_q[0] <= varc_pkg::rnd29(69'(u1_q[1] * v1_q[2]) - 69'(u1_q[2] * v1_q[1]));
      cr2_q[1] <= varc_pkg::rnd29(69'(u1_q[2] * v1_q[0]) - 69'(u1_q[0] * v1_q[2]));
      cr2_q[2] <= varc_pkg::rnd29(69'(u1_q[0] * v1_q[1]) - 69'(u1_q[1] * v1_q[0]));
      d2_q <= varc_pkg::rnd29(69'(u1_q[0] * v1_q[0]) + 69'(u1_q[1] * v1_q[1])
                              + 69'(u1_q[2] * v1_q[2]));
      u2_q <= u1_q;
      v2_q <= v1_q;
      c2_q <= c1_q;
      s2_q <= s1_q;
    end
  end

  // stage 3: w = dot*(1-c), v*c, cross*s
  logic signed [39:0] w3_q, vc3_q [3], cs3_q [3];
  logic signed [31:0] u3_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      w3_q <= varc_pkg::rnd29(69'(d2_q * (32'sd536870912 - 32'(c2_q))));
      for (int l = 0; l < 3; l++) begin
        vc3_q[l] <= varc_pkg::rnd29(69'(v2_q[l] * c2_q));
        cs3_q[l] <= varc_pkg::rnd29(69'(cr2_q[l] * s2_q));
      end
      u3_q <= u2_q;
    end
  end

  // stage 4: u*w and sum
  logic signed [41:0] r4_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        r4_q[l] <= 42'(vc3_q[l]) + 42'(cs3_q[l])
                 + 42'(varc_pkg::rnd29(69'(u3_q[l] * w3_q)));
      end
    end
  end

  // stage 5: saturate into the output register
  logic [31:0] o_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (r4_q[l] > 42'sd2147483647) o_q[l] <= 32'h7fff_ffff;
        else if (r4_q[l] < -42'sd2147483648) o_q[l] <= 32'h8000_0000;
        else o_q[l] <= 32'(r4_q[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[2:0], dv_vld};
      out_vld_q <= vld_q[3];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = o_q[0];
  assign out_y_o     = o_q[1];
  assign out_z_o     = o_q[2];

endmodule
